### design/dqwd_pkg.sv
// ----------------------------------------------------------------------------
// dqwd_pkg
// Types and constants shared by the wheel decoder files.
// ----------------------------------------------------------------------------
`default_nettype none

package dqwd_pkg;

  // Configuration bus
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_DETENT  = 2'd0;
  localparam logic [1:0] REG_RELEASE = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;

  // Register reset values
  localparam logic [2:0]  DETENT_RST  = 3'd2;
  localparam logic [7:0]  RELEASE_RST = 8'd20;
  localparam logic [15:0] TIMEOUT_RST = 16'd500;

  // Quadrature codes {new pair, previous pair}
  localparam logic [3:0] QCW_0  = 4'h1;
  localparam logic [3:0] QCW_1  = 4'h8;
  localparam logic [3:0] QCW_2  = 4'h7;
  localparam logic [3:0] QCW_3  = 4'hE;
  localparam logic [3:0] QCCW_0 = 4'hB;
  localparam logic [3:0] QCCW_1 = 4'h4;
  localparam logic [3:0] QCCW_2 = 4'h2;
  localparam logic [3:0] QCCW_3 = 4'hD;

  // Wheel step encodings
  localparam logic signed [1:0] STEP_NONE = 2'sb00;
  localparam logic signed [1:0] STEP_CW   = 2'sb01;
  localparam logic signed [1:0] STEP_CCW  = 2'sb11;

  localparam logic [7:0] IDLE_MAX = 8'hFF;

  typedef struct packed {
    logic [2:0]  detent_threshold;
    logic [7:0]  release_scans;
    logic [15:0] motion_timeout;
  } cfg_t;

endpackage

`default_nettype wire

### design/dqwd_if.sv
// ----------------------------------------------------------------------------
// dqwd_in_if / dqwd_out_if
// Valid/ready channels for scan requests and decoder results.
// ----------------------------------------------------------------------------
`default_nettype none

interface dqwd_in_if;
  logic        valid;
  logic        ready;
  logic        pin_a;
  logic        pin_b;
  logic        button_pin;
  logic [31:0] now_time;

  modport source (output valid, output pin_a, output pin_b, output button_pin,
                  output now_time, input ready);
  modport sink   (input valid, input pin_a, input pin_b, input button_pin,
                  input now_time, output ready);
endinterface

interface dqwd_out_if;
  logic              valid;
  logic              ready;
  logic              key_event;
  logic              key_pressed;
  logic signed [1:0] wheel_step;
  logic              keep_scanning;

  modport source (output valid, output key_event, output key_pressed,
                  output wheel_step, output keep_scanning, input ready);
  modport sink   (input valid, input key_event, input key_pressed,
                  input wheel_step, input keep_scanning, output ready);
endinterface

`default_nettype wire

### design/dqwd_regs.sv
// ----------------------------------------------------------------------------
// dqwd_regs
// APB configuration registers: detent threshold, release scans, timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module dqwd_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel_i,
  input  wire logic                          penable_i,
  input  wire logic                          pwrite_i,
  input  wire logic [dqwd_pkg::PADDR_W-1:0]  paddr_i,
  input  wire logic [dqwd_pkg::PDATA_W-1:0]  pwdata_i,
  output logic      [dqwd_pkg::PDATA_W-1:0]  prdata_o,
  output logic                               pready_o,
  output dqwd_pkg::cfg_t                     cfg_o
);

  dqwd_pkg::cfg_t cfg_q;
  logic [1:0]     idx;
  logic           wr_en;

  assign idx      = paddr_i[3:2];
  assign wr_en    = psel_i && penable_i && pwrite_i;
  assign pready_o = 1'b1;
  assign cfg_o    = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.detent_threshold <= dqwd_pkg::DETENT_RST;
      cfg_q.release_scans    <= dqwd_pkg::RELEASE_RST;
      cfg_q.motion_timeout   <= dqwd_pkg::TIMEOUT_RST;
    end else if (wr_en) begin
      unique case (idx)
        dqwd_pkg::REG_DETENT:  cfg_q.detent_threshold <= pwdata_i[2:0];
        dqwd_pkg::REG_RELEASE: cfg_q.release_scans    <= pwdata_i[7:0];
        dqwd_pkg::REG_TIMEOUT: cfg_q.motion_timeout   <= pwdata_i[15:0];
        default: ;  // unmapped slot, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      dqwd_pkg::REG_DETENT:  prdata_o = {29'd0, cfg_q.detent_threshold};
      dqwd_pkg::REG_RELEASE: prdata_o = {24'd0, cfg_q.release_scans};
      dqwd_pkg::REG_TIMEOUT: prdata_o = {16'd0, cfg_q.motion_timeout};
      default:               prdata_o = '0;
    endcase
  end

endmodule

`default_nettype wire

### design/debounced_quadrature_wheel_decoder_core.sv
// ----------------------------------------------------------------------------
// debounced_quadrature_wheel_decoder_core
// Pipeline: two register stages; an accepted scan request is held in the
// input register, then its result in the result register that drives out_o.
// Throughput: one scan request per cycle unless out_o stalls; one-pass update.
// Reset (rst_ni, async low): both stages empty, all decoder state zero,
// registers at detent 2, release 20, timeout 500.
// ----------------------------------------------------------------------------
`default_nettype none

module debounced_quadrature_wheel_decoder_core #(
  parameter int unsigned WINDOW_DEPTH        = 2,
  parameter int unsigned BUTTON_HISTORY_BITS = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  dqwd_in_if.sink                            in_i,
  dqwd_out_if.source                         out_o,
  input  wire logic                          psel_i,
  input  wire logic                          penable_i,
  input  wire logic                          pwrite_i,
  input  wire logic [dqwd_pkg::PADDR_W-1:0]  paddr_i,
  input  wire logic [dqwd_pkg::PDATA_W-1:0]  pwdata_i,
  output logic      [dqwd_pkg::PDATA_W-1:0]  prdata_o,
  output logic                               pready_o
);

  localparam int unsigned SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned HB     = BUTTON_HISTORY_BITS;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  dqwd_pkg::cfg_t cfg;

  dqwd_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o),
    .cfg_o     (cfg)
  );

  // --------------------------------------------------------------------------
  // Handshake: input register -> update logic -> result register.
  // The input stage keeps taking requests while a result waits, as long as
  // it is itself free or moving on.
  // --------------------------------------------------------------------------
  logic        s1_valid_q;
  logic        s1_a_q, s1_b_q, s1_btn_q;
  logic [31:0] s1_now_q;
  logic        out_valid_q;
  logic        s2_ready;
  logic        advance;

  assign s2_ready   = !out_valid_q || out_o.ready;
  assign advance    = s1_valid_q && s2_ready;
  assign in_i.ready = !s1_valid_q || s2_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) s1_valid_q <= in_i.valid;
      if (s2_ready)   out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_a_q   <= in_i.pin_a;
      s1_b_q   <= in_i.pin_b;
      s1_btn_q <= in_i.button_pin;
      s1_now_q <= in_i.now_time;
    end
  end

  // --------------------------------------------------------------------------
  // Decoder state
  // --------------------------------------------------------------------------
  logic [1:0]        win_q [WINDOW_DEPTH];
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [1:0]        prev_q, prev_d;
  logic signed [4:0] cnt_q, cnt_d;
  logic [HB-1:0]     hist_q, hist_d;
  logic [7:0]        idle_q, idle_d;
  logic [31:0]       last_q, last_d;

  // Update path working values
  logic [1:0]        pair;
  logic [1:0]        sample;
  logic [31:0]       elapsed;
  logic              timed_out;
  logic [3:0]        code;
  logic              cw, ccw;
  logic signed [4:0] cnt_t, cnt_m, cnt_b;
  logic signed [4:0] thr_pos, thr_neg;
  logic [7:0]        idle_m;
  logic [31:0]       last_t;
  logic              key_event, key_pressed, keep;
  logic signed [1:0] step;

  assign sample = {s1_b_q, s1_a_q};

  // Ring slot advances before the store; wraps at the window depth.
  assign slot_d = (slot_q == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_q + 1'b1;

  // Debounce: AND of the window with the new sample already in place.
  always_comb begin
    pair = 2'b11;
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      if (SLOT_W'(i) == slot_d) pair &= sample;
      else                      pair &= win_q[i];
    end
  end

  // Wrap-safe motion timeout.
  assign elapsed   = s1_now_q - last_q;
  assign timed_out = elapsed > {16'd0, cfg.motion_timeout};
  assign cnt_t     = timed_out ? 5'sd0 : cnt_q;
  assign last_t    = timed_out ? s1_now_q : last_q;

  // Quadrature decode; codes with both bits changed fall to neither arm.
  assign code = {pair, prev_q};
  always_comb begin
    cw  = 1'b0;
    ccw = 1'b0;
    unique case (code)
      dqwd_pkg::QCW_0, dqwd_pkg::QCW_1,
      dqwd_pkg::QCW_2, dqwd_pkg::QCW_3:     cw  = 1'b1;
      dqwd_pkg::QCCW_0, dqwd_pkg::QCCW_1,
      dqwd_pkg::QCCW_2, dqwd_pkg::QCCW_3:   ccw = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    if (cw)       cnt_m = cnt_t + 5'sd1;
    else if (ccw) cnt_m = cnt_t - 5'sd1;
    else          cnt_m = cnt_t;
  end

  assign idle_m = (cw || ccw) ? 8'd0 : idle_q;
  assign prev_d = (cw || ccw) ? pair : prev_q;
  assign last_d = (cw || ccw) ? s1_now_q : last_t;

  // Button history; any change in the low byte is a key event.
  assign hist_d      = {hist_q[HB-2:0], s1_btn_q};
  assign key_event   = hist_d[7:0] != hist_q[7:0];
  assign key_pressed = |hist_d[7:0];
  assign cnt_b       = key_event ? 5'sd0 : cnt_m;

  // Detent: strictly beyond +/- threshold emits one step and clears.
  assign thr_pos = $signed({2'b00, cfg.detent_threshold});
  assign thr_neg = -thr_pos;

  always_comb begin
    step  = dqwd_pkg::STEP_NONE;
    cnt_d = cnt_b;
    priority if (cnt_b > thr_pos) begin
      step  = dqwd_pkg::STEP_CW;
      cnt_d = 5'sd0;
    end else if (cnt_b < thr_neg) begin
      step  = dqwd_pkg::STEP_CCW;
      cnt_d = 5'sd0;
    end else begin
      step  = dqwd_pkg::STEP_NONE;
      cnt_d = cnt_b;
    end
  end

  // Keep scanning uses the idle count before its saturating increment.
  assign keep   = (idle_m < cfg.release_scans) || (|hist_d);
  assign idle_d = (idle_m == dqwd_pkg::IDLE_MAX) ? idle_m : idle_m + 8'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) win_q[i] <= 2'b00;
      slot_q <= '0;
      prev_q <= 2'b00;
      cnt_q  <= 5'sd0;
      hist_q <= '0;
      idle_q <= 8'd0;
      last_q <= 32'd0;
    end else if (advance) begin
      win_q[slot_d] <= sample;
      slot_q        <= slot_d;
      prev_q        <= prev_d;
      cnt_q         <= cnt_d;
      hist_q        <= hist_d;
      idle_q        <= idle_d;
      last_q        <= last_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic              r_event_q, r_pressed_q, r_keep_q;
  logic signed [1:0] r_step_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      r_event_q   <= key_event;
      r_pressed_q <= key_pressed;
      r_step_q    <= step;
      r_keep_q    <= keep;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.key_event     = r_event_q;
  assign out_o.key_pressed   = r_pressed_q;
  assign out_o.wheel_step    = r_step_q;
  assign out_o.keep_scanning = r_keep_q;

endmodule

`default_nettype wire

### test/debounced_quadrature_wheel_decoder_core_tb.sv
// ----------------------------------------------------------------------------
// debounced_quadrature_wheel_decoder_core_tb
// Drives scan requests with encoder and button patterns through the decoder,
// predicts each result from a behavioral copy of the decoder state and
// checks every result in order, across register settings and stall mixes.
// ----------------------------------------------------------------------------
`default_nettype none

package wheel_check_pkg;

  typedef struct packed {
    logic        pin_a;
    logic        pin_b;
    logic        button_pin;
    logic [31:0] now_time;
  } scan_t;

  typedef struct packed {
    logic              key_event;
    logic              key_pressed;
    logic signed [1:0] wheel_step;
    logic              keep_scanning;
  } wheel_result_t;

  class wheel_scoreboard;
    // register copies
    logic [2:0]        detent;
    logic [7:0]        release_lim;
    logic [15:0]       timeout;
    // decoder state copies
    logic [1:0]        window [2];
    logic              slot;
    logic [1:0]        prev_pair;
    logic signed [4:0] count;
    logic [31:0]       history;
    logic [7:0]        idle;
    logic [31:0]       last_motion;

    wheel_result_t     expected_q [$];
    int                mismatches;
    int                results_seen;
    int                cw_steps;
    int                ccw_steps;
    int                key_events;
    int                keep_drops;

    function new();
      detent      = dqwd_pkg::DETENT_RST;
      release_lim = dqwd_pkg::RELEASE_RST;
      timeout     = dqwd_pkg::TIMEOUT_RST;
      window[0]   = '0;
      window[1]   = '0;
      slot        = 1'b0;
      prev_pair   = '0;
      count       = '0;
      history     = '0;
      idle        = '0;
      last_motion = '0;
      mismatches  = 0;
      results_seen = 0;
      cw_steps    = 0;
      ccw_steps   = 0;
      key_events  = 0;
      keep_drops  = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        dqwd_pkg::REG_DETENT:  detent      = val[2:0];
        dqwd_pkg::REG_RELEASE: release_lim = val[7:0];
        dqwd_pkg::REG_TIMEOUT: timeout     = val[15:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] %s", $realtime, msg);
    endfunction

    // Accepted scan request: advance the state copy and queue the result.
    function void note_scan(scan_t s);
      logic [31:0]   hist;
      logic [31:0]   delta;
      logic [1:0]    pair;
      logic [3:0]    code;
      int            cnt;
      int            thr;
      wheel_result_t r;
      slot = slot + 1'b1;
      window[slot] = {s.pin_b, s.pin_a};
      hist  = {history[30:0], s.button_pin};
      pair  = window[0] & window[1];
      cnt   = count;
      delta = s.now_time - last_motion;
      if (delta > {16'h0, timeout}) begin
        cnt = 0;
        last_motion = s.now_time;
      end
      code = {pair, prev_pair};
      case (code)
        dqwd_pkg::QCW_0, dqwd_pkg::QCW_1, dqwd_pkg::QCW_2, dqwd_pkg::QCW_3: begin
          cnt++;
          idle = '0;
          prev_pair = pair;
          last_motion = s.now_time;
        end
        dqwd_pkg::QCCW_0, dqwd_pkg::QCCW_1, dqwd_pkg::QCCW_2, dqwd_pkg::QCCW_3: begin
          cnt--;
          idle = '0;
          prev_pair = pair;
          last_motion = s.now_time;
        end
        default: ;
      endcase
      r.key_event = (hist[7:0] != history[7:0]);
      if (r.key_event) cnt = 0;
      history = hist;
      thr = detent;
      r.wheel_step = dqwd_pkg::STEP_NONE;
      if (cnt > thr) begin
        r.wheel_step = dqwd_pkg::STEP_CW;
        cnt = 0;
      end
      if (cnt < -thr) begin
        r.wheel_step = dqwd_pkg::STEP_CCW;
        cnt = 0;
      end
      r.keep_scanning = (idle < release_lim) || (hist != '0);
      if (idle != dqwd_pkg::IDLE_MAX) idle++;
      r.key_pressed = |hist[7:0];
      count = cnt[4:0];
      expected_q.push_back(r);
    endfunction

    // Accepted result: compare with the oldest prediction.
    function void check_result(wheel_result_t got);
      wheel_result_t exp_r;
      results_seen++;
      if (expected_q.size() == 0) begin
        flag($sformatf("unexpected result ev=%0b kp=%0b step=%0d keep=%0b",
                       got.key_event, got.key_pressed, got.wheel_step,
                       got.keep_scanning));
        return;
      end
      exp_r = expected_q.pop_front();
      if (exp_r.wheel_step == dqwd_pkg::STEP_CW) cw_steps++;
      if (exp_r.wheel_step == dqwd_pkg::STEP_CCW) ccw_steps++;
      if (exp_r.key_event) key_events++;
      if (!exp_r.keep_scanning) keep_drops++;
      if (got.key_event !== exp_r.key_event || got.key_pressed !== exp_r.key_pressed ||
          got.wheel_step !== exp_r.wheel_step ||
          got.keep_scanning !== exp_r.keep_scanning)
        flag($sformatf("result %0d: ev %0b/%0b kp %0b/%0b step %0d/%0d keep %0b/%0b (exp/got)",
                       results_seen, exp_r.key_event, got.key_event,
                       exp_r.key_pressed, got.key_pressed,
                       exp_r.wheel_step, got.wheel_step,
                       exp_r.keep_scanning, got.keep_scanning));
    endfunction
  endclass
endpackage

module debounced_quadrature_wheel_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n;

  // APB-style register port
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [dqwd_pkg::PADDR_W-1:0] paddr;
  logic [dqwd_pkg::PDATA_W-1:0] pwdata;
  logic [dqwd_pkg::PDATA_W-1:0] prdata;
  logic                         pready;

  dqwd_in_if  scan_if ();
  dqwd_out_if res_if ();

  wheel_check_pkg::wheel_scoreboard sb = new();

  // Handshake pressure, per-cycle percentages
  int scan_idle_pct = 0;
  int res_stall_pct = 0;

  // Stimulus generator state
  logic [31:0] t_now = '0;
  logic [1:0]  gen_pos = '0;
  bit          gen_dir = 1'b0;
  int          gen_hold = 0;
  bit          btn_level = 1'b0;
  int          btn_hold = 0;
  int          cur_tmo = dqwd_pkg::TIMEOUT_RST;
  int          scans_sent = 0;

  always #4 clk = ~clk;

  debounced_quadrature_wheel_decoder_core u_top (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_i      (scan_if),
    .out_o     (res_if),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready)
  );

  // Result side: check on every accepted result, then pick next cycle's
  // ready at random so that stalls land on any phase of the pipeline.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1)
      sb.check_result('{res_if.key_event, res_if.key_pressed, res_if.wheel_step,
                        res_if.keep_scanning});
    res_if.ready <= ($urandom_range(99) >= res_stall_pct);
  end

  // One scan request: optional idle cycles, then hold valid until accepted.
  // Valid stays high on return so back-to-back requests never glitch it.
  task automatic send_scan(wheel_check_pkg::scan_t s);
    while ($urandom_range(99) < scan_idle_pct) begin
      scan_if.valid <= 1'b0;
      @(posedge clk);
    end
    scan_if.valid      <= 1'b1;
    scan_if.pin_a      <= s.pin_a;
    scan_if.pin_b      <= s.pin_b;
    scan_if.button_pin <= s.button_pin;
    scan_if.now_time   <= s.now_time;
    do @(posedge clk); while (scan_if.ready !== 1'b1);
    sb.note_scan(s);
    scans_sent++;
  endtask

  task automatic send_fields(bit a, bit b, bit btn, logic [31:0] t);
    send_scan('{a, b, btn, t});
  endtask

  // Stop issuing requests until every predicted result has been checked.
  task automatic drain();
    scan_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the write lands when pready is seen.
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  // Registers only change with the decoder empty: drain, pause, then write.
  task automatic apply_cfg(int det, int rel, int tmo);
    drain();
    repeat (4) @(posedge clk);
    write_reg(dqwd_pkg::REG_DETENT, det);
    write_reg(dqwd_pkg::REG_RELEASE, rel);
    write_reg(dqwd_pkg::REG_TIMEOUT, tmo);
    cur_tmo = tmo;
  endtask

  // Random scan: mostly a wheel turning through the Gray sequence with
  // each level held a few scans (debounce needs two), occasional reversal,
  // skipped positions (both pins change), contact glitches, long rests so
  // the idle counter saturates, button presses with bounce, and time jumps
  // around the motion timeout plus the odd arbitrary time value.
  function automatic wheel_check_pkg::scan_t next_scan();
    wheel_check_pkg::scan_t s;
    int                     r;
    logic [1:0]             lvl;
    r = $urandom_range(99);
    if (r < 2)
      t_now = $urandom;
    else if (r < 6)
      t_now = t_now + $urandom_range(0, 2 * cur_tmo + 2);
    else
      t_now = t_now + $urandom_range(0, 12);
    if (gen_hold == 0) begin
      if ($urandom_range(99) < 10) gen_dir = ~gen_dir;
      r = $urandom_range(99);
      if (r < 80)
        gen_pos = gen_dir ? gen_pos + 2'd1 : gen_pos - 2'd1;
      else if (r < 86)
        gen_pos = gen_pos + 2'd2;
      gen_hold = ($urandom_range(99) < 3) ? $urandom_range(20, 300) : $urandom_range(1, 4);
    end
    gen_hold--;
    case (gen_pos)
      2'd0: lvl = 2'b00;
      2'd1: lvl = 2'b10;
      2'd2: lvl = 2'b11;
      default: lvl = 2'b01;
    endcase
    // no glitches during long rests, or they would count as motion
    if (gen_hold < 5 && $urandom_range(99) < 8) lvl = 2'($urandom_range(3));
    s.pin_a = lvl[0];
    s.pin_b = lvl[1];
    if (btn_hold == 0) begin
      btn_level = ($urandom_range(99) < 30);
      btn_hold  = $urandom_range(1, 40);
    end
    btn_hold--;
    s.button_pin = ($urandom_range(99) < 4) ? ~btn_level : btn_level;
    s.now_time = t_now;
    return s;
  endfunction

  initial begin
    int det;
    int rel;
    int tmo;
    rst_n              <= 1'b0;
    scan_if.valid      <= 1'b0;
    scan_if.pin_a      <= 1'b0;
    scan_if.pin_b      <= 1'b0;
    scan_if.button_pin <= 1'b0;
    scan_if.now_time   <= '0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at reset register values: full clockwise and
    // counter-clockwise detents, an illegal jump, button edges, a timeout,
    // time wrap, and a gap of exactly the timeout (no clear).
    send_fields(0, 0, 0, 32'd0);
    send_fields(0, 1, 0, 32'd1);
    send_fields(0, 1, 0, 32'd2);
    send_fields(1, 1, 0, 32'd3);
    send_fields(1, 1, 0, 32'd4);
    send_fields(1, 0, 0, 32'd5);
    send_fields(1, 0, 0, 32'd6);
    send_fields(0, 0, 0, 32'd7);
    send_fields(0, 0, 0, 32'd8);
    send_fields(1, 0, 0, 32'd9);
    send_fields(1, 0, 0, 32'd10);
    send_fields(1, 1, 0, 32'd11);
    send_fields(1, 1, 0, 32'd12);
    send_fields(0, 1, 0, 32'd13);
    send_fields(0, 1, 0, 32'd14);
    send_fields(0, 0, 0, 32'd15);
    send_fields(0, 0, 0, 32'd16);
    send_fields(1, 1, 0, 32'd17);
    send_fields(1, 1, 0, 32'd18);
    send_fields(1, 0, 1, 32'd19);
    send_fields(1, 0, 0, 32'hFFFF_FFFF);
    send_fields(1, 0, 1, 32'd0);
    send_fields(0, 1, 1, 32'h8000_0000);
    send_fields(1, 1, 0, 32'h8000_01F4);
    send_fields(1, 1, 0, 32'h8000_03E9);
    t_now = 32'd1000;

    // Random phases: register setting and stall mix change together.
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin det = dqwd_pkg::DETENT_RST; rel = dqwd_pkg::RELEASE_RST;
                 tmo = dqwd_pkg::TIMEOUT_RST;
                 scan_idle_pct = 0;  res_stall_pct = 0;  end
        1: begin det = 7; rel = 255; tmo = 65535;
                 scan_idle_pct = 77; res_stall_pct = 0;  end
        2: begin det = 0; rel = 0; tmo = 0;
                 scan_idle_pct = 0;  res_stall_pct = 77; end
        3: begin det = 1; rel = 3; tmo = 40; t_now = 32'hFFFF_FF00;
                 scan_idle_pct = 34; res_stall_pct = 34; end
        default: begin
          det = $urandom_range(0, 7); rel = $urandom_range(1, 255);
          tmo = $urandom_range(20, 2000);
          scan_idle_pct = 0; res_stall_pct = 0;
        end
      endcase
      apply_cfg(det, rel, tmo);
      for (int n = 0; n < 260; n++) begin
        // mid-phase hold-off until the pipeline is empty
        if (n == 130 && p == 1) drain();
        send_scan(next_scan());
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Covered %0d scans, %0d results: %0d cw / %0d ccw detents, %0d key events,",
             scans_sent, sb.results_seen, sb.cw_steps, sb.ccw_steps, sb.key_events);
    $display("%0d scan-stop results, five register settings, four stall mixes, %0d errors",
             sb.keep_drops, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("debounced_quadrature_wheel_decoder_core: match");
    else
      $display("debounced_quadrature_wheel_decoder_core: mismatch");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("debounced_quadrature_wheel_decoder_core: mismatch");
    $finish;
  end

endmodule

`default_nettype wire
